// ----- rtl/core/hpg_pkg.sv -----
// Shared types and constants of the Halton point generator.
// Used by hpg_datapath, halton_point_generator, hpg_checker and tb_top; depends on nothing.
package hpg_pkg;

    localparam int INDEX_BITS_DEF = 20;
    localparam int COORD_BITS_DEF = 12;

    localparam int SAMPLE_W = 20;
    localparam int REG_W    = 13;
    localparam int COORD_W  = 12;

    localparam int TERN_DIGITS = 13;
    localparam int TERN_W      = 21;
    localparam logic [TERN_W-1:0] TERN_SCALE = TERN_W'(1594323);

    // floor(v / 3) = (v * RECIP3) >> RECIP3_SHIFT for every 20-bit v.
    localparam logic [SAMPLE_W-1:0] RECIP3 = SAMPLE_W'(699051);
    localparam int RECIP3_SHIFT = 21;

    // For every n below 2^34, floor(n / 3^13) is either
    // ((n >> QEST_SHIFT_IN) * QEST_RECIP) >> QEST_SHIFT or one more than that.
    localparam int QEST_SHIFT_IN = 14;
    localparam int QEST_W        = 24;
    localparam int QEST_SHIFT    = 30;
    localparam logic [QEST_W-1:0] QEST_RECIP =
        QEST_W'((64'd1 << (QEST_SHIFT_IN + QEST_SHIFT)) / 64'(TERN_SCALE));

    localparam int CNT_W = 4;
    localparam logic [CNT_W-1:0] TERN_LAST = CNT_W'(TERN_DIGITS - 1);

    localparam logic [REG_W-1:0] WIDTH_RST  = REG_W'(1920);
    localparam logic [REG_W-1:0] HEIGHT_RST = REG_W'(1080);

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TERN,
        ST_MULT,
        ST_EST,
        ST_FIX,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic tern_step;
        logic mult;
        logic est;
        logic fix;
    } t_dp_ctrl;

endpackage

// ----- rtl/core/hpg_datapath.sv -----
// Datapath of the Halton point generator: base-3 digit unit, scaling
// multipliers and the reciprocal divider by 3^13. Depends on hpg_pkg.
module hpg_datapath import hpg_pkg::*; #(
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                i_clk,
    input  t_dp_ctrl            i_ctrl,
    input  logic [SAMPLE_W-1:0] i_sample_index,
    input  logic [REG_W-1:0]    i_image_width,
    input  logic [REG_W-1:0]    i_image_height,
    output logic [COORD_W-1:0]  o_point_x,
    output logic [COORD_W-1:0]  o_point_y
);

    localparam int PROD2_W = INDEX_BITS + REG_W;
    localparam int PROD3_W = TERN_W + REG_W;
    localparam int RPROD_W = 2 * SAMPLE_W;
    localparam int QPROD_W = (PROD3_W - QEST_SHIFT_IN) + QEST_W;
    localparam int TOP_W   = 17;

    localparam logic [SAMPLE_W-1:0] IDX_MASK = (INDEX_BITS >= SAMPLE_W) ? '1 :
        SAMPLE_W'((64'd1 << INDEX_BITS) - 64'd1);
    localparam logic [TOP_W-1:0] COORD_TOP = TOP_W'((64'd1 << COORD_BITS) - 64'd1);

    logic [SAMPLE_W-1:0]   r_val;
    logic [INDEX_BITS-1:0] r_idx;
    logic [TERN_W-1:0]     r_rev3;
    logic [PROD3_W-1:0]    r_rem;
    logic [REG_W-1:0]      r_quo;
    logic [COORD_W-1:0]    r_x;

    logic [SAMPLE_W-1:0]   idx_masked;
    logic [INDEX_BITS-1:0] rev2;
    logic [RPROD_W-1:0]    rprod;
    logic [SAMPLE_W-1:0]   q3;
    logic [1:0]            digit;
    logic [PROD2_W-1:0]    prod2;
    logic [REG_W-1:0]      x_raw;
    logic [PROD3_W-1:0]    prod3;
    logic [QPROD_W-1:0]    qprod;
    logic [REG_W-1:0]      q_est;
    logic [PROD3_W-1:0]    qd;
    logic [PROD3_W-1:0]    rem;
    logic                  fits;

    assign idx_masked = i_sample_index & IDX_MASK;

    always_comb begin
        for (int k = 0; k < INDEX_BITS; k++) begin
            rev2[k] = r_idx[INDEX_BITS-1-k];
        end
    end

    assign rprod = RPROD_W'(r_val) * RPROD_W'(RECIP3);
    assign q3    = SAMPLE_W'(rprod >> RECIP3_SHIFT);
    assign digit = 2'(r_val - SAMPLE_W'(3) * q3);

    assign prod2 = PROD2_W'(rev2) * PROD2_W'(i_image_width);
    assign x_raw = prod2[PROD2_W-1:INDEX_BITS];
    assign prod3 = PROD3_W'(r_rev3) * PROD3_W'(i_image_height);

    assign qprod = QPROD_W'(r_rem[PROD3_W-1:QEST_SHIFT_IN]) * QPROD_W'(QEST_RECIP);
    assign q_est = qprod[QEST_SHIFT+REG_W-1:QEST_SHIFT];
    assign qd    = PROD3_W'(r_quo) * PROD3_W'(TERN_SCALE);
    assign rem   = r_rem - qd;
    assign fits  = (rem >= PROD3_W'(TERN_SCALE));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_val  <= idx_masked;
            r_idx  <= INDEX_BITS'(idx_masked);
            r_rev3 <= '0;
        end
        if (i_ctrl.tern_step) begin
            r_val  <= q3;
            r_rev3 <= TERN_W'(r_rev3 * TERN_W'(3)) + TERN_W'(digit);
        end
        if (i_ctrl.mult) begin
            r_rem <= prod3;
            if (TOP_W'(x_raw) > COORD_TOP) begin
                r_x <= COORD_TOP[COORD_W-1:0];
            end else begin
                r_x <= x_raw[COORD_W-1:0];
            end
        end
        if (i_ctrl.est) begin
            r_quo <= q_est;
        end
        if (i_ctrl.fix) begin
            if (fits) begin
                r_quo <= r_quo + REG_W'(1);
            end
        end
    end

    assign o_point_x = r_x;
    assign o_point_y = (TOP_W'(r_quo) > COORD_TOP) ? COORD_TOP[COORD_W-1:0]
                                                   : r_quo[COORD_W-1:0];

endmodule

// ----- rtl/core/halton_point_generator.sv -----
// Top level of the 2-D Halton point generator (bases 2 and 3).
// Holds the configuration registers and the sequencer; uses hpg_pkg, hpg_datapath.
//
//   Channel   Signals                                        Transaction
//   input     i_start, o_busy, i_sample_index                i_start && !o_busy
//   result    o_valid, o_point_x, o_point_y                  o_valid, one cycle
//   config    i_cfg_wr_en, i_cfg_addr, i_cfg_wdata           i_cfg_wr_en
//
// Each accepted transaction passes in order through the base-3 digit unit, the
// scaling multipliers, the reciprocal quotient estimate and its correction before
// the o_valid strobe. A new transaction can be taken in the cycle after the strobe.
// Reset is synchronous and active low and restores width 1920 and height 1080.
// The receiver cannot stall the result.
module halton_point_generator import hpg_pkg::*; #(
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [SAMPLE_W-1:0] i_sample_index,
    output logic                o_busy,
    output logic                o_valid,
    output logic [COORD_W-1:0]  o_point_x,
    output logic [COORD_W-1:0]  o_point_y,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_addr,
    input  logic [REG_W-1:0]    i_cfg_wdata
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [REG_W-1:0] r_width;
    logic [REG_W-1:0] r_height;
    t_dp_ctrl         ctrl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_wdata;
                REG_IMAGE_HEIGHT: r_height <= i_cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (i_start) begin
                    n_state = ST_TERN;
                end
            end
            ST_TERN: begin
                if (r_cnt == TERN_LAST) begin
                    n_state = ST_MULT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_MULT: begin
                n_state = ST_EST;
                n_cnt   = '0;
            end
            ST_EST: begin
                n_state = ST_FIX;
            end
            ST_FIX: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_comb begin
        ctrl    = '0;
        o_busy  = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_busy    = 1'b0;
                ctrl.load = i_start;
            end
            ST_TERN: ctrl.tern_step = 1'b1;
            ST_MULT: ctrl.mult      = 1'b1;
            ST_EST:  ctrl.est       = 1'b1;
            ST_FIX:  ctrl.fix       = 1'b1;
            ST_DONE: o_valid        = 1'b1;
            default: o_busy         = 1'b1;
        endcase
    end

    hpg_datapath #(
        .INDEX_BITS(INDEX_BITS),
        .COORD_BITS(COORD_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_ctrl        (ctrl),
        .i_sample_index(i_sample_index),
        .i_image_width (r_width),
        .i_image_height(r_height),
        .o_point_x     (o_point_x),
        .o_point_y     (o_point_y)
    );

endmodule

// ----- tb/sv/hpg_checker.sv -----
// Checker for the Halton point generator: predicts each point from the accepted
// sample index and the current image size, and compares every result strobe.
// Depends on hpg_pkg for widths, reset values and register indexes.
module hpg_checker import hpg_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  logic [SAMPLE_W-1:0] i_sample_index,
    input  logic                i_valid,
    input  logic [COORD_W-1:0]  i_point_x,
    input  logic [COORD_W-1:0]  i_point_y,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_addr,
    input  logic [REG_W-1:0]    i_cfg_wdata,
    output int                  o_failures,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_point;

    logic [REG_W-1:0] image_width;
    logic [REG_W-1:0] image_height;
    t_point           point_q[$];

    function automatic t_point halton_point(input logic [SAMPLE_W-1:0] idx,
                                            input logic [REG_W-1:0] w,
                                            input logic [REG_W-1:0] h);
        logic [SAMPLE_W-1:0] rev2;
        logic [TERN_W-1:0]   rev3;
        logic [SAMPLE_W-1:0] rest;
        logic [63:0]         xs;
        logic [63:0]         ys;
        logic [63:0]         top;
        t_point              p;
        for (int k = 0; k < SAMPLE_W; k++) begin
            rev2[SAMPLE_W-1-k] = idx[k];
        end
        rest = idx;
        rev3 = '0;
        for (int k = 0; k < TERN_DIGITS; k++) begin
            rev3 = TERN_W'(rev3 * TERN_W'(3)) + TERN_W'(rest % 3);
            rest = SAMPLE_W'(rest / 3);
        end
        xs  = (64'(rev2) * 64'(w)) >> INDEX_BITS_DEF;
        ys  = (64'(rev3) * 64'(h)) / 64'(TERN_SCALE);
        top = (64'd1 << COORD_W) - 64'd1;
        p.x = (xs > top) ? '1 : xs[COORD_W-1:0];
        p.y = (ys > top) ? '1 : ys[COORD_W-1:0];
        return p;
    endfunction

    always @(posedge i_clk) begin
        t_point exp_point;
        if (!i_rst_n) begin
            image_width  = WIDTH_RST;
            image_height = HEIGHT_RST;
            point_q.delete();
            o_failures   = 0;
        end else begin
            if (i_valid) begin
                if (point_q.size() == 0) begin
                    o_failures++;
                    $display("%0t: unexpected point x=%0d y=%0d", $time, i_point_x, i_point_y);
                end else begin
                    exp_point = point_q.pop_front();
                    if (i_point_x !== exp_point.x) begin
                        o_failures++;
                        $display("%0t: point_x expected %0d actual %0d",
                                 $time, exp_point.x, i_point_x);
                    end
                    if (i_point_y !== exp_point.y) begin
                        o_failures++;
                        $display("%0t: point_y expected %0d actual %0d",
                                 $time, exp_point.y, i_point_y);
                    end
                end
            end
            if (i_start && !i_busy) begin
                point_q = {point_q, halton_point(i_sample_index, image_width, image_height)};
            end
            if (i_cfg_wr_en) begin
                if (i_cfg_addr == REG_IMAGE_WIDTH) begin
                    image_width = i_cfg_wdata;
                end else if (i_cfg_addr == REG_IMAGE_HEIGHT) begin
                    image_height = i_cfg_wdata;
                end
            end
        end
        o_pending = point_q.size();
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// Top of the Halton point generator testbench: clock, reset, sample indexes and
// image size writes, with the verdict taken from hpg_checker.
// Depends on hpg_pkg, hpg_checker and halton_point_generator.
module tb_top;
    import hpg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 142;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_start;
    logic [SAMPLE_W-1:0] i_sample_index;
    logic                o_busy;
    logic                o_valid;
    logic [COORD_W-1:0]  o_point_x;
    logic [COORD_W-1:0]  o_point_y;
    logic                i_cfg_wr_en;
    logic                i_cfg_addr;
    logic [REG_W-1:0]    i_cfg_wdata;
    int                  failures;
    int                  pending;
    int                  cycle_count;
    bit                  quiet;
    logic [SAMPLE_W-1:0] run_index;

    logic [SAMPLE_W-1:0] edge_indexes[15] = '{
        20'd0, 20'd1, 20'd2, 20'd3, 20'd4, 20'd5, 20'hFFFFF, 20'h80000, 20'h7FFFF,
        20'hAAAAA, 20'h55555, 20'd531441, 20'd531440, 20'd177147, 20'hFFFFE
    };
    logic [REG_W-1:0] phase_width[NUM_PHASES]  = '{
        13'd1920, 13'd1, 13'd4096, 13'd8191, 13'd0, 13'd4097, 13'd640, 13'd4095
    };
    logic [REG_W-1:0] phase_height[NUM_PHASES] = '{
        13'd1080, 13'd4096, 13'd1, 13'd8191, 13'd0, 13'd3, 13'd480, 13'd5000
    };

    halton_point_generator u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_sample_index (i_sample_index),
        .o_busy         (o_busy),
        .o_valid        (o_valid),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    hpg_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_busy         (o_busy),
        .i_sample_index (i_sample_index),
        .i_valid        (o_valid),
        .i_point_x      (o_point_x),
        .i_point_y      (o_point_y),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_failures     (failures),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("halton_point_generator: mismatch");
            $finish;
        end
    end

    task automatic send_index(input logic [SAMPLE_W-1:0] idx);
        int gap;
        if (!quiet && $urandom_range(99) < 18) begin
            gap = $urandom_range(40, 1);
            repeat (gap) begin
                i_start <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_start        <= 1'b1;
        i_sample_index <= idx;
        do begin
            @(posedge i_clk);
        end while (o_busy);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_start <= 1'b0;
        while (pending != 0 || o_busy) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic addr, input logic [REG_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_index();
        int r;
        r = $urandom_range(99);
        if (r < 45) begin
            run_index = run_index + 1'b1;
            return run_index;
        end else if (r < 50) begin
            return '0;
        end else if (r < 55) begin
            return '1;
        end else if (r < 63) begin
            return SAMPLE_W'(1) << $urandom_range(SAMPLE_W - 1);
        end else if (r < 68) begin
            return SAMPLE_W'($urandom_range(64));
        end
        return SAMPLE_W'($urandom);
    endfunction

    initial begin
        i_rst_n        = 1'b0;
        i_start        = 1'b0;
        i_sample_index = '0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_addr     = REG_IMAGE_WIDTH;
        i_cfg_wdata    = '0;
        quiet          = 1'b0;
        run_index      = SAMPLE_W'($urandom_range(1000));
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (edge_indexes[k]) begin
            send_index(edge_indexes[k]);
        end
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(REG_IMAGE_WIDTH, phase_width[p]);
            write_reg(REG_IMAGE_HEIGHT, phase_height[p]);
            quiet = (p == 3);
            send_index('1);
            send_index('0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_index(pick_index());
            end
            drain();
        end

        write_reg(REG_IMAGE_WIDTH, REG_W'($urandom_range(4096, 1)));
        write_reg(REG_IMAGE_HEIGHT, REG_W'($urandom_range(4096, 1)));
        for (int n = 0; n < 20; n++) begin
            send_index(pick_index());
        end
        drain();
        repeat (40) @(negedge i_clk);

        if (failures == 0 && pending == 0) begin
            $display("halton_point_generator: match");
        end else begin
            $display("halton_point_generator: mismatch");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/hpg_pkg.sv
rtl/core/hpg_datapath.sv
rtl/core/halton_point_generator.sv
tb/sv/hpg_checker.sv
tb/sv/tb_top.sv
